// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst is high.
`define WWSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define WWSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/wwss_pkg.sv -----
// Shared constants, types and helper functions of the substring search block.
package wwss_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 4096;
  localparam int PAT_AW      = $clog2(PATTERN_MAX);
  localparam int PLEN_W      = $clog2(PATTERN_MAX + 1);
  localparam int TXT_AW      = $clog2(TEXT_MAX);
  localparam int TLEN_W      = $clog2(TEXT_MAX + 1);
  localparam int POS_W       = 12;

  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_CMP  = 2'd0;
  localparam rd_sel_t RD_LB   = 2'd1;
  localparam rd_sel_t RD_RB   = 2'd2;
  localparam rd_sel_t RD_NEXT = 2'd3;

  typedef logic [1:0] status_code_t;
  localparam status_code_t ST_OK    = 2'd0;
  localparam status_code_t ST_LEN   = 2'd1;
  localparam status_code_t ST_PFLOW = 2'd2;
  localparam status_code_t ST_TFLOW = 2'd3;

  typedef struct packed {
    logic         take;
    logic         rd_en;
    rd_sel_t      rd_sel;
    logic         k_clr;
    logic         j_clr;
    logic         j_inc;
    logic         skip_rd;
    logic         k_add;
    logic         finish;
    logic         hit;
    status_code_t code;
  } cmd_t;

  typedef struct packed {
    logic pflow;
    logic tflow;
    logic bad_len;
    logic fits;
    logic bytes_eq;
    logic j_last;
    logic k_zero;
    logic right_in;
    logic sep;
    logic whole_word;
  } stat_t;

  // Word characters are digits, letters, underscore and every byte from 128 up.
  function automatic logic is_sep(input logic [7:0] c);
    logic word;
    word = c[7]
        || (c >= 8'h30 && c <= 8'h39)
        || (c >= 8'h41 && c <= 8'h5A)
        || (c >= 8'h61 && c <= 8'h7A)
        || (c == 8'h5F);
    return !word;
  endfunction

endpackage

// ----- hw/rtl/wwss_dp.sv -----
// Datapath: pattern, text and skip stores, window counters and result registers.
`include "assert_macros.svh"

module wwss_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  wwss_pkg::cmd_t             cmd,
  output wwss_pkg::stat_t            stat,
  input  logic                       func,
  input  logic [7:0]                 byte_value,
  input  logic                       last,
  input  logic                       cfg_wen,
  input  logic                       cfg_wdata,
  output logic                       done,
  output logic                       found,
  output logic [wwss_pkg::POS_W-1:0] position,
  output logic [1:0]                 status
);

  logic [7:0]                    pat_mem [wwss_pkg::PATTERN_MAX];
  logic [7:0]                    text_mem [wwss_pkg::TEXT_MAX];
  logic [wwss_pkg::PAT_AW-1:0]   skip_mem [256];
  logic [255:0]                  skip_vld;

  logic                          whole_word;
  logic                          pat_closed;
  logic [wwss_pkg::PLEN_W-1:0]   plen;
  logic                          pflow;
  logic [wwss_pkg::TLEN_W-1:0]   tlen;
  logic                          tflow;
  logic [wwss_pkg::TLEN_W-1:0]   k;
  logic [wwss_pkg::PAT_AW-1:0]   j;
  logic [7:0]                    text_q;
  logic [7:0]                    pat_q;
  logic [wwss_pkg::PAT_AW-1:0]   skip_q;
  logic                          skip_vq;

  logic [wwss_pkg::PLEN_W-1:0]   plen_base;
  logic                          pflow_base;
  logic                          pat_room;
  logic                          text_room;
  logic                          pat_wr;
  logic                          text_wr;
  logic [wwss_pkg::TLEN_W-1:0]   m_ext;
  logic [wwss_pkg::TLEN_W-1:0]   km;
  logic [wwss_pkg::TLEN_W-1:0]   rd_addr;
  logic [wwss_pkg::PLEN_W-1:0]   skip_amt;

  // A pattern byte after a closed pattern starts a new one.
  assign plen_base  = pat_closed ? '0 : plen;
  assign pflow_base = pat_closed ? 1'b0 : pflow;
  assign pat_room   = plen_base < wwss_pkg::PLEN_W'(wwss_pkg::PATTERN_MAX);
  assign text_room  = tlen < wwss_pkg::TLEN_W'(wwss_pkg::TEXT_MAX);
  assign pat_wr     = cmd.take && !func && pat_room;
  assign text_wr    = cmd.take && func && text_room;

  assign m_ext = wwss_pkg::TLEN_W'(plen);
  assign km    = k + m_ext;

  always_comb begin
    case (cmd.rd_sel)
      wwss_pkg::RD_CMP: rd_addr = k + wwss_pkg::TLEN_W'(j);
      wwss_pkg::RD_LB:  rd_addr = k - wwss_pkg::TLEN_W'(1);
      default:          rd_addr = km;
    endcase
  end

  // The skip store holds the last place of each byte; the shift is m minus it, or m+1 for a byte not in the pattern.
  assign skip_amt = skip_vq ? (plen - wwss_pkg::PLEN_W'(skip_q))
                            : (plen + wwss_pkg::PLEN_W'(1));

  always_comb begin
    stat.pflow      = pflow;
    stat.tflow      = tflow;
    stat.bad_len    = (plen == '0) || (m_ext > tlen);
    stat.fits       = km <= tlen;
    stat.bytes_eq   = text_q == pat_q;
    stat.j_last     = (wwss_pkg::PLEN_W'(j) + wwss_pkg::PLEN_W'(1)) == plen;
    stat.k_zero     = k == '0;
    stat.right_in   = km < tlen;
    stat.sep        = wwss_pkg::is_sep(text_q);
    stat.whole_word = whole_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      whole_word <= 1'b1;
      pat_closed <= 1'b0;
      plen       <= '0;
      pflow      <= 1'b0;
      tlen       <= '0;
      tflow      <= 1'b0;
      skip_vld   <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cfg_wen) begin
        whole_word <= cfg_wdata;
      end
      if (cmd.take && !func) begin
        if (pat_room) begin
          // A new pattern drops the marks left by the old one.
          skip_vld <= (pat_closed ? 256'(0) : skip_vld) | (256'(1) << byte_value);
          plen <= plen_base + wwss_pkg::PLEN_W'(1);
        end else begin
          plen <= plen_base;
        end
        pflow      <= pflow_base | !pat_room;
        pat_closed <= last;
      end
      if (cmd.take && func) begin
        if (text_room) begin
          tlen <= tlen + wwss_pkg::TLEN_W'(1);
        end else begin
          tflow <= 1'b1;
        end
        if (last) begin
          pat_closed <= 1'b1;
        end
      end
      if (cmd.finish) begin
        tlen  <= '0;
        tflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_add) begin
      k <= k + wwss_pkg::TLEN_W'(skip_amt);
    end
    if (cmd.j_clr) begin
      j <= '0;
    end else if (cmd.j_inc) begin
      j <= j + wwss_pkg::PAT_AW'(1);
    end
    if (cmd.finish) begin
      found    <= cmd.hit;
      position <= cmd.hit ? k[wwss_pkg::POS_W-1:0] : '0;
      status   <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[plen_base[wwss_pkg::PAT_AW-1:0]] <= byte_value;
      skip_mem[byte_value] <= plen_base[wwss_pkg::PAT_AW-1:0];
    end
    pat_q <= pat_mem[j];
  end

  always_ff @(posedge clk) begin
    if (text_wr) begin
      text_mem[tlen[wwss_pkg::TXT_AW-1:0]] <= byte_value;
    end
    if (cmd.rd_en) begin
      text_q <= text_mem[rd_addr[wwss_pkg::TXT_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.skip_rd) begin
      skip_q  <= skip_mem[text_q];
      skip_vq <= skip_vld[text_q];
    end
  end

  `WWSS_ASSERT(a_found_ok, done && found |-> status == wwss_pkg::ST_OK, "match reported with an error status")
  `WWSS_ASSERT(a_miss_zero, done && !found |-> position == '0, "position not zero on a miss")
  `WWSS_ASSERT(a_text_cleared, cmd.finish |=> tlen == '0 && !tflow, "text not cleared after a search")

endmodule

// ----- hw/rtl/wwss_ctrl.sv -----
// Controller: accepts items and sequences the quick search over the stored text.
`include "assert_macros.svh"

module wwss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            func,
  input  logic            last,
  input  wwss_pkg::stat_t stat,
  output wwss_pkg::cmd_t  cmd,
  output logic            busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_CRD  = 4'd2;
  localparam logic [3:0] S_CCHK = 4'd3;
  localparam logic [3:0] S_LRD  = 4'd4;
  localparam logic [3:0] S_LCHK = 4'd5;
  localparam logic [3:0] S_RRD  = 4'd6;
  localparam logic [3:0] S_RCHK = 4'd7;
  localparam logic [3:0] S_ADV  = 4'd8;
  localparam logic [3:0] S_SK1  = 4'd9;
  localparam logic [3:0] S_SK2  = 4'd10;
  localparam logic [3:0] S_WIN  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = wwss_pkg::RD_CMP;
    cmd.code   = wwss_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        cmd.take = start;
        if (start && func && last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.pflow) begin
          cmd.finish = 1'b1;
          cmd.code   = wwss_pkg::ST_PFLOW;
          state_next = S_IDLE;
        end else if (stat.tflow) begin
          cmd.finish = 1'b1;
          cmd.code   = wwss_pkg::ST_TFLOW;
          state_next = S_IDLE;
        end else if (stat.bad_len) begin
          cmd.finish = 1'b1;
          cmd.code   = wwss_pkg::ST_LEN;
          state_next = S_IDLE;
        end else begin
          cmd.k_clr  = 1'b1;
          cmd.j_clr  = 1'b1;
          state_next = S_CRD;
        end
      end
      S_CRD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CCHK;
      end
      S_CCHK: begin
        if (!stat.bytes_eq) begin
          state_next = S_ADV;
        end else if (!stat.j_last) begin
          cmd.j_inc  = 1'b1;
          state_next = S_CRD;
        end else if (stat.whole_word) begin
          state_next = S_LRD;
        end else begin
          cmd.finish = 1'b1;
          cmd.hit    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LRD: begin
        if (stat.k_zero) begin
          state_next = S_RRD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = wwss_pkg::RD_LB;
          state_next = S_LCHK;
        end
      end
      S_LCHK: begin
        state_next = stat.sep ? S_RRD : S_ADV;
      end
      S_RRD: begin
        if (stat.right_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = wwss_pkg::RD_RB;
          state_next = S_RCHK;
        end else begin
          cmd.finish = 1'b1;
          cmd.hit    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RCHK: begin
        if (stat.sep) begin
          cmd.finish = 1'b1;
          cmd.hit    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        // No byte after the window means the text is exhausted.
        if (stat.right_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = wwss_pkg::RD_NEXT;
          state_next = S_SK1;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SK1: begin
        cmd.skip_rd = 1'b1;
        state_next  = S_SK2;
      end
      S_SK2: begin
        cmd.k_add  = 1'b1;
        cmd.j_clr  = 1'b1;
        state_next = S_WIN;
      end
      S_WIN: begin
        if (stat.fits) begin
          state_next = S_CRD;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `WWSS_ASSERT(a_search_starts, start && !busy && func && last |=> busy, "text end did not start a search")
  `WWSS_ASSERT(a_finish_idle, cmd.finish |=> state == S_IDLE, "finish did not return to idle")
  `WWSS_ASSERT(a_eval_cause, state == S_EVAL |-> $past(start && func && last), "search entered without a text end")

endmodule

// ----- hw/rtl/whole_word_substring_search.sv -----
// Top level of the whole-word substring search block.
//
//  Channel   Direction  Handshake            Payload
//  input     in         start / busy         func, byte_value, last
//  result    out        done (one cycle)     found, position, status
//  config    in         cfg_wen              cfg_wdata (whole_word)
//
// Pattern and text bytes load at one item per cycle into on-chip stores while
// busy is low. A text item marked last raises busy while the search walks the
// text memory over its single read port: length checks, a read and a check per
// compared byte or whole-word boundary, and per window shift reads of the next
// byte and its skip entry, the shift and a fit check. An error status from the
// length checks shows on done. Synchronous reset clears the lengths and flags,
// sets whole_word to 1 and needs no clearing pass. The result cannot be stalled.
module whole_word_substring_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func,
  input  logic [7:0]                 byte_value,
  input  logic                       last,
  input  logic                       cfg_wen,
  input  logic                       cfg_wdata,
  output logic                       done,
  output logic                       found,
  output logic [wwss_pkg::POS_W-1:0] position,
  output logic [1:0]                 status
);

  wwss_pkg::cmd_t  cmd;
  wwss_pkg::stat_t stat;

  wwss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func),
    .last  (last),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  wwss_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .func       (func),
    .byte_value (byte_value),
    .last       (last),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .found      (found),
    .position   (position),
    .status     (status)
  );

endmodule
